FILE: sv/assert_macros.svh
// Assertion macros shared by the keypad scan tone PWM RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KPST_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");
`define KPST_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");
`else
`define KPST_ASSERT(label, clk, rst_n, prop)
`define KPST_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: sv/kpst_pkg.sv
// Package: widths, reset values, register indexes and tone ROM of the keypad tone block.
package kpst_pkg;

	localparam int PRESC_W   = 16;
	localparam int CNT_W     = 7;
	localparam int ROM_W     = 8;
	localparam int ROM_DIM   = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [PRESC_W-1:0] PRESC_RESET = 16'd39999;
	localparam logic [CNT_W-1:0]   DUTY_RESET  = 7'd50;
	localparam logic [CNT_W-1:0]   TOP_RESET   = 7'd99;

	localparam logic [CFG_IDX_W-1:0] REG_DUTY_COMPARE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TOP   = 2'd1;

	// 4000000/(f*10), row-major, 0 = no tone
	localparam logic [ROM_W-1:0] TONE_ROM [16] = '{
		8'd152, 8'd136, 8'd121, 8'd0,
		8'd114, 8'd102, 8'd90,  8'd0,
		8'd80,  8'd76,  8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0
	};

	typedef struct packed {
		logic               adv;
		logic [PRESC_W-1:0] pending;
		logic [CNT_W-1:0]   top;
	} timer_ctl_t;

	function automatic logic [ROM_W-1:0] tone_lookup(input logic [1:0] r, input logic [1:0] c);
		return TONE_ROM[{r, c}];
	endfunction

endpackage

FILE: sv/kpst_timer.sv
// Prescaled PWM period timer with buffered prescaler reload.
`include "assert_macros.svh"

module kpst_timer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  kpst_pkg::timer_ctl_t           ctl,
	output logic [kpst_pkg::CNT_W-1:0]     period_count
);

	logic [kpst_pkg::PRESC_W-1:0] presc_q;
	logic [kpst_pkg::PRESC_W-1:0] active_q;
	logic [kpst_pkg::CNT_W-1:0]   period_q;
	logic                         presc_wrap;
	logic                         period_wrap;

	assign presc_wrap  = presc_q >= active_q;
	assign period_wrap = period_q >= ctl.top;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presc_q  <= '0;
			active_q <= kpst_pkg::PRESC_RESET;
			period_q <= '0;
		end else if (ctl.adv) begin
			if (presc_wrap) begin
				presc_q <= '0;
				if (period_wrap) begin
					period_q <= '0;
					active_q <= ctl.pending;
				end else begin
					period_q <= period_q + kpst_pkg::CNT_W'(1);
				end
			end else begin
				presc_q <= presc_q + kpst_pkg::PRESC_W'(1);
			end
		end
	end

	assign period_count = period_q;

	`KPST_ASSERT(a_presc_clears, clk, arst_n, ctl.adv && presc_wrap |=> presc_q == '0)
	`KPST_ASSERT(a_idle_holds, clk, arst_n, !ctl.adv |=> $stable(presc_q) && $stable(period_q))
	`KPST_ASSERT(a_reload_on_wrap, clk, arst_n, ctl.adv && presc_wrap && period_wrap |=> active_q == $past(ctl.pending))

endmodule

FILE: sv/keypad_scan_tone_pwm_core.sv
// Top level: keypad matrix scanner driving a prescaled PWM tone generator.
// Usage:
//   Input channel (in_valid/in_stall): one beat per timer tick, carrying
//   row_levels and sample_strobe. A beat with sample_strobe high samples the
//   current key and steps the scan, row-major over PAD_DIM x PAD_DIM keys.
//   Output channel (out_valid/out_stall): one beat per input beat, with
//   column_drive and buzzer_level as they stood before that tick's update.
//   Config channel (cfg_valid/cfg_ready): cfg_ready is always high; index 0
//   writes duty_compare, index 1 writes period_top, other indexes are ignored.
// Timing:
//   An output beat is valid in the cycle after its input beat. Throughput is
//   one beat per cycle while out_stall is low: all of a tick's work is one
//   pass from the state registers into the output register, and the next beat
//   is taken while the output register is read out in the same cycle.
// Stall: while out_stall holds a full output register, in_stall is high and
//   no tick is taken, so the timer and scan freeze.
// Reset: scan at key 0, tone silent, prescaler 39999, duty 50, period top 99.
`include "assert_macros.svh"

module keypad_scan_tone_pwm_core #(
	parameter int PAD_DIM = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [3:0]                         row_levels,
	input  logic                               sample_strobe,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [3:0]                         column_drive,
	output logic                               buzzer_level,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [kpst_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [kpst_pkg::CNT_W-1:0]         cfg_data
);

	localparam int IDX_W = (PAD_DIM > 1) ? $clog2(PAD_DIM) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAD_DIM - 1);

	logic [kpst_pkg::CNT_W-1:0]   duty_q;
	logic [kpst_pkg::CNT_W-1:0]   top_q;
	logic [IDX_W-1:0]             row_q;
	logic [IDX_W-1:0]             col_q;
	logic                         pressed_q;
	logic [kpst_pkg::PRESC_W-1:0] pending_q;
	logic [kpst_pkg::CNT_W-1:0]   compare_q;
	logic [3:0]                   column_q;
	logic                         buzzer_q;
	logic                         out_valid_q;

	logic                         in_acc;
	logic [7:0]                   row_ext;
	logic [7:0]                   col_ext;
	logic                         row_in_rom;
	logic                         col_in_rom;
	logic                         hit;
	logic                         last_pos;
	logic [kpst_pkg::ROM_W-1:0]   rom_val;
	logic                         pressed_d;
	logic [kpst_pkg::PRESC_W-1:0] pending_d;
	logic [kpst_pkg::CNT_W-1:0]   compare_d;
	logic [3:0]                   column_now;
	logic                         buzzer_now;
	logic [kpst_pkg::CNT_W-1:0]   period_count;
	kpst_pkg::timer_ctl_t         tctl;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q && out_stall;
	assign in_acc    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= kpst_pkg::DUTY_RESET;
			top_q  <= kpst_pkg::TOP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				kpst_pkg::REG_DUTY_COMPARE: duty_q <= cfg_data;
				kpst_pkg::REG_PERIOD_TOP:   top_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign row_ext    = 8'(row_q);
	assign col_ext    = 8'(col_q);
	assign row_in_rom = row_ext < 8'(kpst_pkg::ROM_DIM);
	assign col_in_rom = col_ext < 8'(kpst_pkg::ROM_DIM);
	assign last_pos   = (row_q == LAST_IDX) && (col_q == LAST_IDX);
	assign hit        = sample_strobe && row_in_rom && row_levels[row_ext[1:0]];
	assign rom_val    = (row_in_rom && col_in_rom) ?
		kpst_pkg::tone_lookup(row_ext[1:0], col_ext[1:0]) : '0;

	always_comb begin
		pressed_d = pressed_q;
		pending_d = pending_q;
		compare_d = compare_q;
		if (hit) begin
			pressed_d = 1'b1;
			if (rom_val != '0) begin
				pending_d = kpst_pkg::PRESC_W'(rom_val);
				compare_d = duty_q;
			end else begin
				compare_d = '0;
			end
		end
		if (sample_strobe && last_pos) begin
			if (!pressed_d) begin
				compare_d = '0;
			end
			pressed_d = 1'b0;
		end
	end

	assign column_now = col_in_rom ? (4'b0001 << col_ext[1:0]) : 4'b0000;
	assign buzzer_now = period_count < compare_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			col_q     <= '0;
			pressed_q <= 1'b0;
			pending_q <= kpst_pkg::PRESC_RESET;
			compare_q <= '0;
		end else if (in_acc) begin
			pressed_q <= pressed_d;
			pending_q <= pending_d;
			compare_q <= compare_d;
			if (sample_strobe) begin
				if (col_q == LAST_IDX) begin
					col_q <= '0;
					row_q <= last_pos ? '0 : row_q + IDX_W'(1);
				end else begin
					col_q <= col_q + IDX_W'(1);
				end
			end
		end
	end

	assign tctl.adv     = in_acc;
	assign tctl.pending = pending_d;
	assign tctl.top     = top_q;

	kpst_timer u_timer (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (tctl),
		.period_count (period_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			column_q <= column_now;
			buzzer_q <= buzzer_now;
		end
	end

	assign out_valid    = out_valid_q;
	assign column_drive = column_q;
	assign buzzer_level = buzzer_q;

	`KPST_ASSERT(a_beat_lands, clk, arst_n, in_valid && !in_stall |=> out_valid)
	`KPST_ASSERT(a_col_onehot, clk, arst_n, out_valid |-> $onehot0(column_drive))
	`KPST_NEVER(a_pos_range, clk, arst_n, row_q > LAST_IDX || col_q > LAST_IDX)

endmodule
